[rtl/core/sdve_pkg.sv]
// shared types and constants for the sample delta variable-length encoder
package sdve_pkg;

  // per-block code counters
  typedef logic [16:0] count_t;
  localparam count_t CNT_FIELD_MAX = 17'h1FFFF;

  // code prefixes
  localparam logic [7:0] PFX_NEG_ONE = 8'h80;
  localparam logic [7:0] PFX_TWO     = 8'hC0;
  localparam logic [7:0] PFX_THREE   = 8'hE0;
  localparam logic [7:0] PFX_ESC     = 8'hF0;

  // magnitude limits of each code form
  localparam logic [31:0] SHORT_POS_MAX = 32'd127;
  localparam logic [31:0] SHORT_NEG_MAX = 32'd63;
  localparam logic [31:0] TWO_MAX       = 32'd4095;
  localparam logic [31:0] THREE_MAX     = 32'd524287;

  // code length in bytes
  typedef logic [2:0] code_len_t;
  localparam code_len_t LEN_ONE   = 3'd1;
  localparam code_len_t LEN_TWO   = 3'd2;
  localparam code_len_t LEN_THREE = 3'd3;
  localparam code_len_t LEN_FIVE  = 3'd5;

  // code byte buffer, first byte in the top bits
  localparam int CODE_BUF_W = 40;

  // queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    count_t short_cnt;
    count_t two_cnt;
    count_t three_cnt;
    count_t five_cnt;
  } counts_t;

  // one classified sample waiting to be serialized
  typedef struct packed {
    logic [CODE_BUF_W-1:0] bytes;
    code_len_t             len;
    counts_t               counts;
  } code_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/sdve_front.sv]
// front end: delta, code classification, byte packing and block counters
module sdve_front #(
  parameter longint unsigned MAX_BLOCK_SAMPLES = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            sample,
  input  logic                   block_start,
  input  logic                   push,
  output sdve_pkg::code_entry_t  entry
);

  localparam sdve_pkg::count_t CNT_LIMIT =
    (MAX_BLOCK_SAMPLES < longint'(sdve_pkg::CNT_FIELD_MAX)) ?
      sdve_pkg::count_t'(MAX_BLOCK_SAMPLES) : sdve_pkg::CNT_FIELD_MAX;

  logic [31:0]       previous_sample;
  sdve_pkg::counts_t counters;
  sdve_pkg::counts_t counters_next;
  sdve_pkg::counts_t base;

  logic [31:0] prev_eff;
  logic [31:0] d;
  logic [31:0] m;
  logic        neg;
  logic        is_short;
  logic        is_two;
  logic        is_three;

  function automatic sdve_pkg::count_t bump(input sdve_pkg::count_t c);
    bump = (c < CNT_LIMIT) ? c + 17'd1 : c;
  endfunction

  // difference against the previous sample, taken as zero at block start
  always_comb begin
    prev_eff = block_start ? 32'd0 : previous_sample;
    d        = sample - prev_eff;
    neg      = d[31];
    m        = neg ? ~d : d;
    is_short = (!neg && (m <= sdve_pkg::SHORT_POS_MAX)) ||
               (neg && (m <= sdve_pkg::SHORT_NEG_MAX));
    is_two   = !is_short && (m <= sdve_pkg::TWO_MAX);
    is_three = !is_short && !is_two && (m <= sdve_pkg::THREE_MAX);
  end

  // counters after this sample
  always_comb begin
    base          = block_start ? '0 : counters;
    counters_next = base;
    if (is_short) begin
      counters_next.short_cnt = bump(base.short_cnt);
    end else if (is_two) begin
      counters_next.two_cnt = bump(base.two_cnt);
    end else if (is_three) begin
      counters_next.three_cnt = bump(base.three_cnt);
    end else begin
      counters_next.five_cnt = bump(base.five_cnt);
    end
  end

  // byte packing, first byte at the top
  always_comb begin
    entry.counts = counters_next;
    if (is_short && !neg) begin
      entry.bytes = {m[7:0], 32'd0};
      entry.len   = sdve_pkg::LEN_ONE;
    end else if (is_short) begin
      entry.bytes = {sdve_pkg::PFX_NEG_ONE | {2'b00, m[5:0]}, 32'd0};
      entry.len   = sdve_pkg::LEN_ONE;
    end else if (is_two) begin
      entry.bytes = {sdve_pkg::PFX_TWO | {3'b000, neg, m[11:8]}, m[7:0], 24'd0};
      entry.len   = sdve_pkg::LEN_TWO;
    end else if (is_three) begin
      entry.bytes = {sdve_pkg::PFX_THREE | {4'b0000, neg, m[18:16]},
                     m[15:8], m[7:0], 16'd0};
      entry.len   = sdve_pkg::LEN_THREE;
    end else begin
      entry.bytes = {sdve_pkg::PFX_ESC, d};
      entry.len   = sdve_pkg::LEN_FIVE;
    end
  end

  // state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      counters        <= '0;
    end else if (push) begin
      previous_sample <= sample;
      counters        <= counters_next;
    end
  end

endmodule

[rtl/core/sdve_queue.sv]
// short queue of classified samples between front and back
module sdve_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sdve_pkg::code_entry_t wr_entry,
  input  logic                  pop,
  output sdve_pkg::code_entry_t rd_entry,
  output sdve_pkg::q_status_t   status
);

  sdve_pkg::code_entry_t              slots [sdve_pkg::QUEUE_DEPTH];
  logic [sdve_pkg::QPTR_W-1:0]        wr_ptr;
  logic [sdve_pkg::QPTR_W-1:0]        rd_ptr;
  logic [sdve_pkg::QCNT_W-1:0]        fill;

  // status and head
  always_comb begin
    status.full  = (fill == sdve_pkg::QCNT_W'(sdve_pkg::QUEUE_DEPTH));
    status.empty = (fill == '0);
    rd_entry     = slots[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

[rtl/core/sdve_back.sv]
// back end: serializes queued codes one byte per cycle into the output register, holding while out_stall is high
module sdve_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sdve_pkg::code_entry_t head,
  input  sdve_pkg::q_status_t   status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            code_byte,
  output logic                  last_of_sample,
  output sdve_pkg::counts_t     out_counts
);

  logic [31:0]          cur_bytes;
  sdve_pkg::code_len_t  cur_rem;
  sdve_pkg::counts_t    cur_counts;
  logic                 slot_free;
  logic                 from_cur;
  logic                 from_head;

  // byte source: rest of current code first, else queue head
  always_comb begin
    slot_free = !out_valid || !out_stall;
    from_cur  = (cur_rem != '0);
    from_head = !from_cur && !status.empty;
    pop       = slot_free && from_head;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_rem   <= '0;
    end else if (slot_free) begin
      if (from_cur) begin
        out_valid <= 1'b1;
        cur_rem   <= cur_rem - 1'b1;
      end else if (from_head) begin
        out_valid <= 1'b1;
        cur_rem   <= head.len - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (from_cur) begin
        code_byte      <= cur_bytes[31:24];
        last_of_sample <= (cur_rem == sdve_pkg::LEN_ONE);
        out_counts     <= cur_counts;
        cur_bytes      <= {cur_bytes[23:0], 8'd0};
      end else if (from_head) begin
        code_byte      <= head.bytes[39:32];
        last_of_sample <= (head.len == sdve_pkg::LEN_ONE);
        out_counts     <= head.counts;
        cur_bytes      <= head.bytes[31:0];
        cur_counts     <= head.counts;
      end
    end
  end

endmodule

[rtl/core/sample_delta_varlen_encoder.sv]
// top level of the sample delta variable-length encoder
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   sample, block_start
//  output    out        out_valid / out_stall code_byte, last_of_sample, four counts
//
// A sample is classified and packed in the cycle it is accepted and queued.
// The serializer emits one byte per cycle while out_stall is low; a sample
// is coded in 1, 2, 3 or 5 bytes, and the byte-wide output register sets the rate.
// The four-entry queue lets input accept while output is stalled, until full.
// Synchronous reset clears previous sample, counters, queue and output valid.
module sample_delta_varlen_encoder #(
  parameter longint unsigned MAX_BLOCK_SAMPLES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] sample,
  input  logic        block_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_byte,
  output logic        last_of_sample,
  output logic [16:0] short_code_count,
  output logic [16:0] two_byte_count,
  output logic [16:0] three_byte_count,
  output logic [16:0] five_byte_count
);

  sdve_pkg::code_entry_t wr_entry;
  sdve_pkg::code_entry_t head;
  sdve_pkg::q_status_t   q_status;
  sdve_pkg::counts_t     out_counts;
  logic                  push;
  logic                  pop;

  // accept whenever the queue has room
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  sdve_front #(
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .block_start (block_start),
    .push        (push),
    .entry       (wr_entry)
  );

  sdve_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .status   (q_status)
  );

  sdve_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .status         (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_byte      (code_byte),
    .last_of_sample (last_of_sample),
    .out_counts     (out_counts)
  );

  // count fields
  assign short_code_count = out_counts.short_cnt;
  assign two_byte_count   = out_counts.two_cnt;
  assign three_byte_count = out_counts.three_cnt;
  assign five_byte_count  = out_counts.five_cnt;

`ifndef ASSERT_OFF
  // a non-empty queue means the output register holds a valid byte next cycle
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty |=> out_valid)
    else $error("queued sample not presented at output");

  // bytes of one sample follow without a gap and carry the same counts
  a_code_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_sample |=> out_valid && $stable(out_counts))
    else $error("code bytes of one sample split or counts changed");

  // nothing pops from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule
